// ----- design/tdf_pkg.sv -----
// Package for the trial-division factorizer: types and fixed constants.
package tdf_pkg;

  localparam int EXP_BITS   = 5;
  localparam int COUNT_BITS = 4;

  localparam logic [EXP_BITS-1:0]   EXP_MAX   = 5'd31;
  localparam logic [EXP_BITS-1:0]   EXP_ONE   = 5'd1;
  localparam logic [COUNT_BITS-1:0] MAX_ITEMS = 4'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CHECK,
    ST_DIV,
    ST_JUDGE,
    ST_FINAL,
    ST_FLUSH
  } tdf_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic take_quot;
    logic emit_div;
    logic advance;
    logic emit_rem;
    logic flush;
  } tdf_cmd_t;

  typedef struct packed {
    logic special;
    logic sq_le_n;
    logic div_done;
    logic rem_zero;
    logic mult_nz;
    logic at_cap;
    logic n_gt1;
  } tdf_status_t;

endpackage

// ----- design/trial_division_factorizer_unit.sv -----
// Trial-division factorizer: top level joining controller and datapath.
// Each divisor tried takes one division in the one-bit-per-cycle divider, plus one more
// division each time it divides the cofactor; 0, 1 and -1 need no division at all.
// One transaction at a time (busy high). Results appear one per strobe cycle; the receiver
// cannot stall. Reset (rst_n low, synchronous) returns to idle and drops any transaction
// in progress.
module trial_division_factorizer_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [VALUE_BITS-1:0]   in_value,
  output logic                           out_valid,
  output logic signed [VALUE_BITS-1:0]   out_factor,
  output logic [tdf_pkg::EXP_BITS-1:0]   out_exponent,
  output logic                           out_last
);

  import tdf_pkg::*;

  tdf_cmd_t    cmd;
  tdf_status_t status;

  tdf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  tdf_datapath #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_value    (in_value),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_factor  (out_factor),
    .out_exponent(out_exponent),
    .out_last    (out_last)
  );

endmodule

// ----- design/tdf_divider.sv -----
// Restoring divider, one quotient bit per cycle, quotient and remainder held after done.
module tdf_divider #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [VALUE_BITS-1:0] remainder,
  output logic                  done
);

  localparam int W  = VALUE_BITS;
  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  div_r, div_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          active_r, active_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  always_comb begin
    shifted    = {rem_r, quo_r[W-1]};
    diff       = shifted - {1'b0, div_r};
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    div_nxt    = div_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    done_nxt   = 1'b0;
    if (start) begin
      rem_nxt    = '0;
      quo_nxt    = dividend;
      div_nxt    = divisor;
      cnt_nxt    = CW'(VALUE_BITS);
      active_nxt = 1'b1;
    end else if (active_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

// ----- design/tdf_datapath.sv -----
// Datapath: cofactor, trial divisor and its square, multiplicity, pending item, result registers.
module tdf_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic signed [VALUE_BITS-1:0]   in_value,
  input  tdf_pkg::tdf_cmd_t              cmd,
  output tdf_pkg::tdf_status_t           status,
  output logic                           out_valid,
  output logic signed [VALUE_BITS-1:0]   out_factor,
  output logic [tdf_pkg::EXP_BITS-1:0]   out_exponent,
  output logic                           out_last
);

  import tdf_pkg::*;

  localparam int W   = VALUE_BITS;
  localparam int PW  = VALUE_BITS / 2 + 2;
  localparam int SQW = VALUE_BITS + 2;

  logic [W-1:0]          n_r, n_nxt;
  logic [PW-1:0]         p_r, p_nxt;
  logic [SQW-1:0]        sq_r, sq_nxt;
  logic [EXP_BITS-1:0]   c_r, c_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  special_r, special_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [W-1:0]          pend_factor_r, pend_factor_nxt;
  logic [EXP_BITS-1:0]   pend_exp_r, pend_exp_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [W-1:0]          out_factor_r, out_factor_nxt;
  logic [EXP_BITS-1:0]   out_exp_r, out_exp_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [W-1:0]          v_u;
  logic                  neg;
  logic [W-1:0]          mag;
  logic [W-1:0]          p_ext;
  logic [W-1:0]          quo;
  logic [W-1:0]          rem;
  logic [W-1:0]          div_dividend;
  logic                  div_done;
  logic                  emit;
  logic [W-1:0]          new_factor;
  logic [EXP_BITS-1:0]   new_exp;

  assign v_u   = in_value;
  assign neg   = v_u[W-1];
  assign mag   = neg ? (~v_u + W'(1)) : v_u;
  assign p_ext = {{(W-PW){1'b0}}, p_r};

  // a repeat division starts from the quotient being taken in the same cycle
  assign div_dividend = cmd.take_quot ? quo : n_r;

  tdf_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (p_ext),
    .quotient (quo),
    .remainder(rem),
    .done     (div_done)
  );

  assign emit       = cmd.emit_div | cmd.emit_rem;
  assign new_factor = cmd.emit_div ? p_ext : n_r;
  assign new_exp    = cmd.emit_div ? c_r : EXP_ONE;

  always_comb begin
    n_nxt           = n_r;
    p_nxt           = p_r;
    sq_nxt          = sq_r;
    c_nxt           = c_r;
    count_nxt       = count_r;
    special_nxt     = special_r;
    pend_v_nxt      = pend_v_r;
    pend_factor_nxt = pend_factor_r;
    pend_exp_nxt    = pend_exp_r;
    out_valid_nxt   = 1'b0;
    out_factor_nxt  = out_factor_r;
    out_exp_nxt     = out_exp_r;
    out_last_nxt    = out_last_r;

    if (cmd.load) begin
      n_nxt        = mag;
      p_nxt        = PW'(2);
      sq_nxt       = SQW'(4);
      c_nxt        = '0;
      pend_exp_nxt = EXP_ONE;
      special_nxt  = 1'b0;
      if (v_u == '0) begin
        special_nxt     = 1'b1;
        pend_v_nxt      = 1'b1;
        pend_factor_nxt = '0;
        count_nxt       = COUNT_BITS'(1);
      end else if (v_u == W'(1)) begin
        special_nxt     = 1'b1;
        pend_v_nxt      = 1'b1;
        pend_factor_nxt = W'(1);
        count_nxt       = COUNT_BITS'(1);
      end else if (neg) begin
        pend_v_nxt      = 1'b1;
        pend_factor_nxt = '1;
        count_nxt       = COUNT_BITS'(1);
      end else begin
        pend_v_nxt = 1'b0;
        count_nxt  = '0;
      end
    end

    if (cmd.take_quot) begin
      n_nxt = quo;
      c_nxt = (c_r == EXP_MAX) ? EXP_MAX : c_r + EXP_ONE;
    end

    if (cmd.advance) begin
      p_nxt  = p_r + PW'(1);
      sq_nxt = sq_r + {{(SQW-PW-1){1'b0}}, p_r, 1'b0} + SQW'(1);
      c_nxt  = '0;
    end

    if (emit) begin
      out_valid_nxt   = pend_v_r;
      out_factor_nxt  = pend_factor_r;
      out_exp_nxt     = pend_exp_r;
      out_last_nxt    = 1'b0;
      pend_v_nxt      = 1'b1;
      pend_factor_nxt = new_factor;
      pend_exp_nxt    = new_exp;
      count_nxt       = count_r + COUNT_BITS'(1);
    end

    if (cmd.flush) begin
      out_valid_nxt  = pend_v_r;
      out_factor_nxt = pend_factor_r;
      out_exp_nxt    = pend_exp_r;
      out_last_nxt   = 1'b1;
      pend_v_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      p_r         <= PW'(2);
      sq_r        <= SQW'(4);
      c_r         <= '0;
      count_r     <= '0;
      special_r   <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      n_r         <= n_nxt;
      p_r         <= p_nxt;
      sq_r        <= sq_nxt;
      c_r         <= c_nxt;
      count_r     <= count_nxt;
      special_r   <= special_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_factor_r <= pend_factor_nxt;
    pend_exp_r    <= pend_exp_nxt;
    out_factor_r  <= out_factor_nxt;
    out_exp_r     <= out_exp_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign status.special  = special_r;
  assign status.sq_le_n  = sq_r <= {2'b00, n_r};
  assign status.div_done = div_done;
  assign status.rem_zero = rem == '0;
  assign status.mult_nz  = c_r != '0;
  assign status.at_cap   = count_r == (MAX_ITEMS - COUNT_BITS'(1));
  assign status.n_gt1    = n_r > W'(1);

  assign out_valid    = out_valid_r;
  assign out_factor   = out_factor_r;
  assign out_exponent = out_exp_r;
  assign out_last     = out_last_r;

endmodule

// ----- design/tdf_ctrl.sv -----
// Controller state machine: sequences load, trial divisions, item emission and flush.
module tdf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  tdf_pkg::tdf_status_t status,
  output tdf_pkg::tdf_cmd_t    cmd,
  output logic                 busy
);

  import tdf_pkg::*;

  tdf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = status.special ? ST_FLUSH : ST_CHECK;
      end
      ST_CHECK: begin
        if (status.sq_le_n) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_FINAL;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_nxt = ST_JUDGE;
        end
      end
      ST_JUDGE: begin
        if (status.rem_zero) begin
          cmd.take_quot = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_CHECK;
          if (status.mult_nz) begin
            cmd.emit_div = 1'b1;
            if (status.at_cap) begin
              state_nxt = ST_FLUSH;
            end
          end
        end
      end
      ST_FINAL: begin
        if (status.n_gt1) begin
          cmd.emit_rem = 1'b1;
        end
        state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
